// ----- hw/rtl/particle_velocity_integrate_bounce_macros.svh -----
// Assertion macros for the particle integrator.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef PARTICLE_VELOCITY_INTEGRATE_BOUNCE_MACROS_SVH
`define PARTICLE_VELOCITY_INTEGRATE_BOUNCE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PVIB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PVIB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pvib_pkg.sv -----
// Shared types, constants and helpers for the particle integrator.
// No dependencies; used by every module of the block.
package pvib_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DAMP_BITS     = 16;
	localparam int DATA_W        = 32;
	localparam int DT_W          = 20;
	localparam int BOX_W         = 16;
	localparam int RAD_W         = 25;
	localparam int DIAM_W        = RAD_W + 1;
	localparam int SPEED_W       = 31;
	localparam int DAMP_W        = 17;
	localparam int CFG_W         = 31;
	localparam int CFG_IDX_W     = 3;
	localparam int LANES         = 2;
	localparam int SQ_IN_W       = 64;
	localparam int SQ_OUT_W      = 32;
	localparam int SQ_REM_W      = SQ_OUT_W + 2;
	localparam int SC_PROD_W     = DATA_W + SPEED_W;
	localparam int SC_QUO_W      = SPEED_W;
	localparam int WALL_LAT      = 3;

	localparam logic [BOX_W-1:0]   BOX_WIDTH_RST  = 16'd800;
	localparam logic [BOX_W-1:0]   BOX_HEIGHT_RST = 16'd600;
	localparam logic [RAD_W-1:0]   RADIUS_RST     = 25'd327680;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 31'd655360;
	localparam logic [DAMP_W-1:0]  DAMPING_RST    = 17'd52429;

	localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOX_WIDTH  = 3'd0,
		CFG_BOX_HEIGHT = 3'd1,
		CFG_RADIUS     = 3'd2,
		CFG_MAX_SPEED  = 3'd3,
		CFG_DAMPING_X  = 3'd4,
		CFG_DAMPING_Y  = 3'd5
	} cfg_idx_t;

	// Lane 0 is the x axis, lane 1 the y axis.
	typedef struct packed {
		logic                         dzero;
		logic [LANES-1:0][DATA_W-1:0] pos;
		logic [LANES-1:0][DATA_W-1:0] vel;
	} pv_t;

	typedef struct packed {
		pv_t             pv;
		logic [LANES-1:0] neg;
		logic [DT_W-1:0] dt;
	} acc_tag_t;

	typedef struct packed {
		pv_t                             pv;
		logic                            lim;
		logic [LANES-1:0][SC_PROD_W-1:0] prod;
	} sq_tag_t;

	typedef struct packed {
		pv_t  pv;
		logic lim;
	} sc_tag_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic [DATA_W-1:0] r;
		if (x > 64'sd2147483647) begin
			r = Q_MAX;
		end else if (x < -64'sd2147483648) begin
			r = Q_MIN;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/pvib_div.sv -----
// Pipelined two-lane restoring divider, one quotient bit per stage.
// Depends on pvib_pkg; a tag travels alongside each transaction.
module pvib_div import pvib_pkg::*; #(
	parameter int DW = 32,
	parameter int QW = 48,
	parameter int TW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  logic [LANES-1:0][DW-1:0] in_den,
	input  logic [LANES-1:0][DW-1:0] in_rem,
	input  logic [LANES-1:0][QW-1:0] in_low,
	input  logic [TW-1:0]            in_tag,
	output logic                     out_vld,
	output logic [LANES-1:0][QW-1:0] out_quo,
	output logic [TW-1:0]            out_tag
);

	logic                     vld_s [QW];
	logic [LANES-1:0][DW-1:0] den_s [QW];
	logic [LANES-1:0][DW-1:0] rem_s [QW];
	logic [LANES-1:0][QW-1:0] low_s [QW];
	logic [TW-1:0]            tag_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                     vld_in;
		logic [LANES-1:0][DW-1:0] den_in;
		logic [LANES-1:0][DW-1:0] rem_in;
		logic [LANES-1:0][DW-1:0] rem_nx;
		logic [LANES-1:0][QW-1:0] low_in;
		logic [LANES-1:0][QW-1:0] low_nx;
		logic [TW-1:0]            tag_in;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign den_in = in_den;
			assign rem_in = in_rem;
			assign low_in = in_low;
			assign tag_in = in_tag;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign den_in = den_s[k-1];
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		always_comb begin
			for (int i = 0; i < LANES; i++) begin
				logic [DW:0] t;
				logic        ge;
				t         = {rem_in[i], low_in[i][QW-1]};
				ge        = (t >= {1'b0, den_in[i]});
				rem_nx[i] = ge ? DW'(t - {1'b0, den_in[i]}) : t[DW-1:0];
				low_nx[i] = {low_in[i][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			den_s[k] <= den_in;
			rem_s[k] <= rem_nx;
			low_s[k] <= low_nx;
			tag_s[k] <= tag_in;
		end
	end

	assign out_vld = vld_s[QW-1];
	assign out_quo = low_s[QW-1];
	assign out_tag = tag_s[QW-1];

endmodule

// ----- hw/rtl/pvib_sqrt.sv -----
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on pvib_pkg; a tag travels alongside each transaction.
module pvib_sqrt import pvib_pkg::*; #(
	parameter int TW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [SQ_IN_W-1:0]  in_val,
	input  logic [TW-1:0]       in_tag,
	output logic                out_vld,
	output logic [SQ_OUT_W-1:0] out_root,
	output logic [TW-1:0]       out_tag
);

	logic                vld_s  [SQ_OUT_W];
	logic [SQ_REM_W-1:0] rem_s  [SQ_OUT_W];
	logic [SQ_OUT_W-1:0] root_s [SQ_OUT_W];
	logic [SQ_IN_W-1:0]  val_s  [SQ_OUT_W];
	logic [TW-1:0]       tag_s  [SQ_OUT_W];

	for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
		logic                vld_in;
		logic [SQ_REM_W-1:0] rem_in;
		logic [SQ_REM_W-1:0] rem_nx;
		logic [SQ_OUT_W-1:0] root_in;
		logic [SQ_OUT_W-1:0] root_nx;
		logic [SQ_IN_W-1:0]  val_in;
		logic [TW-1:0]       tag_in;
		logic [SQ_REM_W+1:0] t;
		logic [SQ_REM_W+1:0] trial;
		logic                ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign root_in = '0;
			assign val_in  = in_val;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign val_in  = val_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		always_comb begin
			t       = {rem_in, val_in[SQ_IN_W-1 -: 2]};
			trial   = (SQ_REM_W + 2)'({root_in, 2'b01});
			ge      = (t >= trial);
			rem_nx  = ge ? SQ_REM_W'(t - trial) : t[SQ_REM_W-1:0];
			root_nx = {root_in[SQ_OUT_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_nx;
			root_s[k] <= root_nx;
			val_s[k]  <= {val_in[SQ_IN_W-3:0], 2'b00};
			tag_s[k]  <= tag_in;
		end
	end

	assign out_vld  = vld_s[SQ_OUT_W-1];
	assign out_root = root_s[SQ_OUT_W-1];
	assign out_tag  = tag_s[SQ_OUT_W-1];

endmodule

// ----- hw/rtl/pvib_wall.sv -----
// Three-stage position update, wall bounce and clamp for both axes.
// Depends on pvib_pkg; a tag travels alongside each transaction.
module pvib_wall import pvib_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int TW        = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [LANES-1:0][DATA_W-1:0] in_pos,
	input  logic [LANES-1:0][DATA_W-1:0] in_vel,
	input  logic [LANES-1:0][BOX_W-1:0]  box,
	input  logic [LANES-1:0][DAMP_W-1:0] damp,
	input  logic [DIAM_W-1:0]            diam,
	input  logic [TW-1:0]                in_tag,
	output logic                         out_vld,
	output logic [LANES-1:0][DATA_W-1:0] out_pos,
	output logic [LANES-1:0][DATA_W-1:0] out_vel,
	output logic [TW-1:0]                out_tag
);

	localparam int CW = (BOX_W + FRAC_BITS + 2 > DATA_W + 1) ? BOX_W + FRAC_BITS + 2 : DATA_W + 1;
	localparam int PW = DATA_W + 1 + DAMP_W + 1;

	logic                         vld_s1, vld_s2, vld_s3;
	logic [LANES-1:0][DATA_W-1:0] pos_s1, vel_s1;
	logic [LANES-1:0][DATA_W:0]   nv_s1;
	logic [LANES-1:0][CW-1:0]     upper_s1;
	logic [LANES-1:0][DAMP_W-1:0] damp_s1;
	logic [TW-1:0]                tag_s1, tag_s2, tag_s3;
	logic [LANES-1:0][DATA_W-1:0] pos_s2, vel_s2;
	logic [LANES-1:0][PW-1:0]     prod_s2;
	logic [LANES-1:0]             bounce_s2;
	logic [LANES-1:0][DATA_W-1:0] pos_s3, vel_s3;

	logic [LANES-1:0][DATA_W-1:0] pos_nx1;
	logic [LANES-1:0][DATA_W:0]   nv_nx1;
	logic [LANES-1:0][CW-1:0]     upper_nx1;
	logic [LANES-1:0][DATA_W-1:0] pos_nx2;
	logic [LANES-1:0][PW-1:0]     prod_nx2;
	logic [LANES-1:0]             bounce_nx2;
	logic [LANES-1:0][DATA_W-1:0] vel_nx3;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pos_nx1[i]   = sat32(64'($signed(in_pos[i])) + 64'($signed(in_vel[i])));
			nv_nx1[i]    = (DATA_W + 1)'(-$signed({in_vel[i][DATA_W-1], in_vel[i]}));
			upper_nx1[i] = (CW'(box[i]) << FRAC_BITS) - CW'(diam);
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic signed [CW-1:0] p;
			logic signed [CW-1:0] c;
			p             = CW'($signed(pos_s1[i]));
			bounce_nx2[i] = (p < 0) || (p >= $signed(upper_s1[i]));
			c             = (p < 0) ? '0 : p;
			if (c > $signed(upper_s1[i])) begin
				c = $signed(upper_s1[i]);
			end
			pos_nx2[i]  = sat32(64'(c));
			prod_nx2[i] = PW'($signed(nv_s1[i]) * $signed({1'b0, damp_s1[i]}));
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			vel_nx3[i] = bounce_s2[i] ? sat32(64'($signed(prod_s2[i]) >>> DAMP_BITS))
				: vel_s2[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1    <= pos_nx1;
		vel_s1    <= in_vel;
		nv_s1     <= nv_nx1;
		upper_s1  <= upper_nx1;
		damp_s1   <= damp;
		tag_s1    <= in_tag;
		pos_s2    <= pos_nx2;
		vel_s2    <= vel_s1;
		prod_s2   <= prod_nx2;
		bounce_s2 <= bounce_nx2;
		tag_s2    <= tag_s1;
		pos_s3    <= pos_s2;
		vel_s3    <= vel_nx3;
		tag_s3    <= tag_s2;
	end

	assign out_vld = vld_s3;
	assign out_pos = pos_s3;
	assign out_vel = vel_s3;
	assign out_tag = tag_s3;

endmodule

// ----- hw/rtl/particle_velocity_integrate_bounce.sv -----
// Top level of the particle integrator: one integration step with wall bounce.
// Depends on pvib_pkg, pvib_div, pvib_sqrt, pvib_wall and the assertion macros.
//
// Usage:
//   A transaction is accepted at each rising edge with start high; busy is
//   always low, so one particle can enter every cycle.
//   Each result appears on the new_* ports and density_zero for exactly one
//   cycle with done high. Results leave in input order.
//   The pipeline is made of the acceleration divider (32 + FRAC_BITS stages),
//   the square root (32 stages), the speed scaling divider (31 stages) and
//   eleven stages of multipliers, adders and the wall logic.
//   Throughput is one particle per cycle.
//   The receiver cannot stall; every result must be taken when done is high.
//   Registers are written through cfg_wen, cfg_idx and cfg_wdata while no
//   transaction is in flight; writes to unknown indexes are ignored.
//   Reset clears all pipeline valid bits and loads the register defaults.
`include "particle_velocity_integrate_bounce_macros.svh"
module particle_velocity_integrate_bounce import pvib_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] vel_x,
	input  logic signed [DATA_W-1:0] vel_y,
	input  logic signed [DATA_W-1:0] force_x,
	input  logic signed [DATA_W-1:0] force_y,
	input  logic [DATA_W-1:0]        density,
	input  logic [DT_W-1:0]          step_seconds,
	output logic                     done,
	output logic signed [DATA_W-1:0] new_pos_x,
	output logic signed [DATA_W-1:0] new_pos_y,
	output logic signed [DATA_W-1:0] new_vel_x,
	output logic signed [DATA_W-1:0] new_vel_y,
	output logic                     density_zero,
	input  logic                     cfg_wen,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [CFG_W-1:0]         cfg_wdata
);

	localparam int ACC_W  = DATA_W + FRAC_BITS;
	localparam int MUL_W  = DATA_W + DT_W + 1;
	localparam int SQ_LAT = SQ_OUT_W;
	localparam int SC_LAT = SC_QUO_W;

	logic [BOX_W-1:0]   box_w_q, box_h_q;
	logic [RAD_W-1:0]   radius_q;
	logic [SPEED_W-1:0] max_speed_q;
	logic [DAMP_W-1:0]  damp_x_q, damp_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_w_q     <= BOX_WIDTH_RST;
			box_h_q     <= BOX_HEIGHT_RST;
			radius_q    <= RADIUS_RST;
			max_speed_q <= MAX_SPEED_RST;
			damp_x_q    <= DAMPING_RST;
			damp_y_q    <= DAMPING_RST;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_BOX_WIDTH: begin
					box_w_q <= cfg_wdata[BOX_W-1:0];
				end
				CFG_BOX_HEIGHT: begin
					box_h_q <= cfg_wdata[BOX_W-1:0];
				end
				CFG_RADIUS: begin
					radius_q <= cfg_wdata[RAD_W-1:0];
				end
				CFG_MAX_SPEED: begin
					max_speed_q <= cfg_wdata[SPEED_W-1:0];
				end
				CFG_DAMPING_X: begin
					damp_x_q <= cfg_wdata[DAMP_W-1:0];
				end
				CFG_DAMPING_Y: begin
					damp_y_q <= cfg_wdata[DAMP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	// Input register: force magnitudes and signs feed the divider.
	logic                         vld_s1;
	acc_tag_t                     tag_s1;
	logic [LANES-1:0][DATA_W-1:0] fabs_s1;
	logic [DATA_W-1:0]            den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.pv.dzero  <= (density == '0);
		tag_s1.pv.pos[0] <= pos_x;
		tag_s1.pv.pos[1] <= pos_y;
		tag_s1.pv.vel[0] <= vel_x;
		tag_s1.pv.vel[1] <= vel_y;
		tag_s1.neg       <= {force_y[DATA_W-1], force_x[DATA_W-1]};
		tag_s1.dt        <= step_seconds;
		fabs_s1[0]       <= force_x[DATA_W-1] ? DATA_W'(-force_x) : force_x;
		fabs_s1[1]       <= force_y[DATA_W-1] ? DATA_W'(-force_y) : force_y;
		den_s1           <= density;
	end

	logic [LANES-1:0][ACC_W-1:0]  acc_low;
	logic                         acc_vld;
	logic [LANES-1:0][ACC_W-1:0]  acc_quo;
	acc_tag_t                     acc_tag;

	assign acc_low[0] = {fabs_s1[0], {FRAC_BITS{1'b0}}};
	assign acc_low[1] = {fabs_s1[1], {FRAC_BITS{1'b0}}};

	pvib_div #(
		.DW (DATA_W),
		.QW (ACC_W),
		.TW ($bits(acc_tag_t))
	) u_acc_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_den  ({den_s1, den_s1}),
		.in_rem  ('0),
		.in_low  (acc_low),
		.in_tag  (tag_s1),
		.out_vld (acc_vld),
		.out_quo (acc_quo),
		.out_tag (acc_tag)
	);

	// Acceleration: apply the sign and saturate the quotient; zero if density is 0.
	logic                         vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	acc_tag_t                     tag_s2, tag_s3;
	logic [LANES-1:0][DATA_W-1:0] ax_s2;
	logic [LANES-1:0][DATA_W-1:0] ax_nx;
	logic [LANES-1:0][MUL_W-1:0]  prod_s3;
	pv_t                          pv_s4, pv_s5, pv_s6, pv_s7;
	logic [LANES-1:0][DATA_W-1:0] mag_s5;
	logic [LANES-1:0][63:0]       sq_s6;
	logic [2*SPEED_W-1:0]         msq_s6;
	logic [LANES-1:0][SC_PROD_W-1:0] sp_s6, sp_s7;
	logic [SQ_IN_W-1:0]           sum_s7;
	logic                         lim_s7;
	pv_t                          pv_s8;
	logic [LANES-1:0][DATA_W-1:0] vel_s8;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic            hi;
			logic [ACC_W-1:0] q;
			q  = acc_quo[i];
			hi = |q[ACC_W-1:DATA_W];
			if (acc_tag.pv.dzero) begin
				ax_nx[i] = '0;
			end else if (!acc_tag.neg[i]) begin
				ax_nx[i] = (hi || q[DATA_W-1]) ? Q_MAX : q[DATA_W-1:0];
			end else begin
				ax_nx[i] = (hi || (q[DATA_W-1] && |q[DATA_W-2:0])) ? Q_MIN
					: DATA_W'(-$signed(q[DATA_W-1:0]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s2 <= acc_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2      <= acc_tag;
		ax_s2       <= ax_nx;
		tag_s3      <= tag_s2;
		pv_s4.dzero <= tag_s3.pv.dzero;
		pv_s4.pos   <= tag_s3.pv.pos;
		pv_s5       <= pv_s4;
		pv_s6       <= pv_s5;
		pv_s7       <= pv_s6;
		msq_s6      <= max_speed_q * max_speed_q;
		sum_s7      <= sq_s6[0] + sq_s6[1];
		lim_s7      <= (sq_s6[0] + sq_s6[1]) > 64'(msq_s6);
		sp_s7       <= sp_s6;
		for (int i = 0; i < LANES; i++) begin
			prod_s3[i]      <= MUL_W'($signed(ax_s2[i]) * $signed({1'b0, tag_s2.dt}));
			pv_s4.vel[i]    <= sat32(64'($signed(tag_s3.pv.vel[i]))
				+ 64'($signed(prod_s3[i]) >>> FRAC_BITS));
			mag_s5[i]       <= pv_s4.vel[i][DATA_W-1] ? DATA_W'(-$signed(pv_s4.vel[i]))
				: pv_s4.vel[i];
			sq_s6[i]        <= 64'(mag_s5[i]) * 64'(mag_s5[i]);
			sp_s6[i]        <= SC_PROD_W'(mag_s5[i]) * SC_PROD_W'(max_speed_q);
		end
	end

	sq_tag_t                 sq_in_tag;
	logic                    sq_vld;
	logic [SQ_OUT_W-1:0]     sq_root;
	sq_tag_t                 sq_tag;

	assign sq_in_tag.pv   = pv_s7;
	assign sq_in_tag.lim  = lim_s7;
	assign sq_in_tag.prod = sp_s7;

	pvib_sqrt #(
		.TW ($bits(sq_tag_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.in_val   (sum_s7),
		.in_tag   (sq_in_tag),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_tag  (sq_tag)
	);

	logic [LANES-1:0][SQ_OUT_W-1:0] sc_rem;
	logic [LANES-1:0][SC_QUO_W-1:0] sc_low;
	sc_tag_t                        sc_in_tag;
	logic                           sc_vld;
	logic [LANES-1:0][SC_QUO_W-1:0] sc_quo;
	sc_tag_t                        sc_tag;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sc_rem[i] = sq_tag.prod[i][SC_PROD_W-1:SC_QUO_W];
			sc_low[i] = sq_tag.prod[i][SC_QUO_W-1:0];
		end
	end

	assign sc_in_tag.pv  = sq_tag.pv;
	assign sc_in_tag.lim = sq_tag.lim;

	pvib_div #(
		.DW (SQ_OUT_W),
		.QW (SC_QUO_W),
		.TW ($bits(sc_tag_t))
	) u_scale_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.in_den  ({sq_root, sq_root}),
		.in_rem  (sc_rem),
		.in_low  (sc_low),
		.in_tag  (sc_in_tag),
		.out_vld (sc_vld),
		.out_quo (sc_quo),
		.out_tag (sc_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= sc_vld;
		end
	end

	always_ff @(posedge clk) begin
		pv_s8 <= sc_tag.pv;
		for (int i = 0; i < LANES; i++) begin
			if (!sc_tag.lim) begin
				vel_s8[i] <= sc_tag.pv.vel[i];
			end else if (sc_tag.pv.vel[i][DATA_W-1]) begin
				vel_s8[i] <= DATA_W'(-$signed({1'b0, sc_quo[i]}));
			end else begin
				vel_s8[i] <= {1'b0, sc_quo[i]};
			end
		end
	end

	logic [LANES-1:0][DATA_W-1:0] w_pos, w_vel;
	logic                         w_dzero;

	pvib_wall #(
		.FRAC_BITS (FRAC_BITS),
		.TW        (1)
	) u_wall (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s8),
		.in_pos  (pv_s8.pos),
		.in_vel  (vel_s8),
		.box     ({box_h_q, box_w_q}),
		.damp    ({damp_y_q, damp_x_q}),
		.diam    ({radius_q, 1'b0}),
		.in_tag  (pv_s8.dzero),
		.out_vld (done),
		.out_pos (w_pos),
		.out_vel (w_vel),
		.out_tag (w_dzero)
	);

	assign new_pos_x    = w_pos[0];
	assign new_pos_y    = w_pos[1];
	assign new_vel_x    = w_vel[0];
	assign new_vel_y    = w_vel[1];
	assign density_zero = w_dzero;

	`PVIB_ASSERT_NEXT(a_accept, start && !busy, vld_s1, "accepted transaction not captured")
	`PVIB_ASSERT_IMPL(a_sqrt_lat, sq_vld, $past(vld_s7, SQ_LAT), "square root latency slip")
	`PVIB_ASSERT_IMPL(a_scale_lat, sc_vld, $past(sq_vld, SC_LAT), "scaling divider latency slip")
	`PVIB_ASSERT_IMPL(a_wall_lat, done, $past(vld_s8, WALL_LAT), "result without a transaction")

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for particle_velocity_integrate_bounce.
// Depends on pvib_pkg and the block's RTL; predicts every result in-line and
// compares it against the block output in order.
module tb_top import pvib_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QB = FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 150;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	typedef struct {
		logic signed [DATA_W-1:0] px, py, vx, vy, fx, fy;
		logic [DATA_W-1:0]        dens;
		logic [DT_W-1:0]          dt;
	} particle_t;

	typedef struct {
		logic signed [DATA_W-1:0] px, py, vx, vy;
		logic                     dz;
	} motion_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [DATA_W-1:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic signed [DATA_W-1:0] force_x = '0, force_y = '0;
	logic [DATA_W-1:0] density = '0;
	logic [DT_W-1:0] step_seconds = '0;
	logic done;
	logic signed [DATA_W-1:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
	logic density_zero;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	particle_velocity_integrate_bounce uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies used by the predictor.
	longint box_w = 800, box_h = 600, radius = 327680, speed_cap = 655360;
	longint damp_x = 52429, damp_y = 52429;

	particle_t pending[$];
	motion_t   expected_motion[$];
	particle_t cur;
	int  idle_left = 0;
	bit  gaps_on = 1'b1;
	int  errors = 0, accepted = 0, checked = 0, settings_run = 0;
	longint cycles = 0;

	function automatic longint clamp_q32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] n);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint scale_toward_zero(longint v, bit [63:0] num, bit [63:0] den);
		bit [63:0] m, q;
		m = (v < 0) ? -v : v;
		q = (m * num) / den;
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void bounce_axis(inout longint p, inout longint v,
			input longint box, input longint damp, input longint diam);
		longint lim, upper;
		lim = box << QB;
		upper = lim - diam;
		if (p < 0 || p + diam >= lim) v = clamp_q32((-v * damp) >>> DAMP_BITS);
		if (p < 0) p = 0;
		if (p > upper) p = upper;
		p = clamp_q32(p);
	endfunction

	function automatic motion_t integrate_particle(particle_t it);
		motion_t r;
		longint px, py, vx, vy, ax, ay, diam;
		bit [63:0] mx, my, sum, mag;
		px = it.px; py = it.py; vx = it.vx; vy = it.vy;
		diam = radius * 2;
		r.dz = (it.dens == 0);
		if (!r.dz) begin
			ax = clamp_q32(scale_toward_zero(it.fx, 64'd1 << QB, it.dens));
			ay = clamp_q32(scale_toward_zero(it.fy, 64'd1 << QB, it.dens));
			vx = clamp_q32(vx + ((ax * longint'(it.dt)) >>> QB));
			vy = clamp_q32(vy + ((ay * longint'(it.dt)) >>> QB));
		end
		mx = (vx < 0) ? -vx : vx;
		my = (vy < 0) ? -vy : vy;
		sum = mx * mx + my * my;
		if (sum > 64'(speed_cap * speed_cap)) begin
			mag = int_sqrt(sum);
			vx = scale_toward_zero(vx, speed_cap, mag);
			vy = scale_toward_zero(vy, speed_cap, mag);
		end
		px = clamp_q32(px + vx);
		py = clamp_q32(py + vy);
		bounce_axis(px, vx, box_w, damp_x, diam);
		bounce_axis(py, vy, box_h, damp_y, diam);
		r.px = px; r.py = py; r.vx = vx; r.vy = vy;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH result %0d %s: got %0d expected %0d", checked, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_motion.insert(expected_motion.size(), integrate_particle(cur));
				accepted++;
				if (gaps_on && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 11);
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					pos_x <= cur.px; pos_y <= cur.py;
					vel_x <= cur.vx; vel_y <= cur.vy;
					force_x <= cur.fx; force_y <= cur.fy;
					density <= cur.dens; step_seconds <= cur.dt;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		motion_t w;
		if (arst_n && done) begin
			if (expected_motion.size() == 0) begin
				report_mismatch("unexpected transaction", 0, 0);
			end else begin
				w = expected_motion.pop_front();
				if (new_pos_x !== w.px) report_mismatch("new_pos_x", new_pos_x, w.px);
				if (new_pos_y !== w.py) report_mismatch("new_pos_y", new_pos_y, w.py);
				if (new_vel_x !== w.vx) report_mismatch("new_vel_x", new_vel_x, w.vx);
				if (new_vel_y !== w.vy) report_mismatch("new_vel_y", new_vel_y, w.vy);
				if (density_zero !== w.dz) report_mismatch("density_zero", density_zero, w.dz);
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, expected_motion.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		case (idx)
			CFG_BOX_WIDTH:  box_w = val & 64'hFFFF;
			CFG_BOX_HEIGHT: box_h = val & 64'hFFFF;
			CFG_RADIUS:     radius = val & 64'h1FF_FFFF;
			CFG_MAX_SPEED:  speed_cap = val & 64'h7FFF_FFFF;
			CFG_DAMPING_X:  damp_x = val & 64'h1_FFFF;
			CFG_DAMPING_Y:  damp_y = val & 64'h1_FFFF;
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_all(longint bw, longint bh, longint rad, longint spd,
			longint dx, longint dy);
		write_reg(CFG_BOX_WIDTH, bw);
		write_reg(CFG_BOX_HEIGHT, bh);
		write_reg(CFG_RADIUS, rad);
		write_reg(CFG_MAX_SPEED, spd);
		write_reg(CFG_DAMPING_X, dx);
		write_reg(CFG_DAMPING_Y, dy);
		settings_run++;
	endtask

	task automatic push_item(longint px, longint py, longint vx, longint vy,
			longint fx, longint fy, longint d, longint dt);
		particle_t it;
		it.px = px; it.py = py; it.vx = vx; it.vy = vy;
		it.fx = fx; it.fy = fy; it.dens = d; it.dt = dt;
		pending.insert(pending.size(), it);
	endtask

	function automatic longint near_wall(longint box);
		longint lim;
		lim = box << QB;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 8 << QB);
			1: return lim - 2 * radius - $urandom_range(0, 8 << QB);
			2: return -longint'($urandom_range(0, 4 << QB));
			default: return $urandom_range(0, 32'(lim));
		endcase
	endfunction

	function automatic longint small_signed(int mag);
		return longint'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	task automatic push_random(int n);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				push_item(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
					int'($urandom), int'($urandom),
					($urandom_range(0, 9) == 0) ? 0 : $urandom, $urandom_range(0, 20'hFFFFF));
			end else begin
				push_item(near_wall(box_w), near_wall(box_h),
					small_signed(20 << QB), small_signed(20 << QB),
					small_signed(400 << QB), small_signed(400 << QB),
					($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1 << (QB - 2), 8 << QB),
					$urandom_range(0, 1 << (QB - 3)));
			end
		end
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || start || idle_left != 0 || expected_motion.size() != 0)
			@(posedge clk);
	endtask

	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(0, 0, 0, 0, 0, 0, 0, 0);
		push_item(100 << QB, 100 << QB, 0, 0, 50 << QB, -(50 << QB), 0, 1 << QB);
		push_item(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 32'hFFFF_FFFF, 20'hFFFFF);
		push_item(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 1, 20'hFFFFF);
		push_item(100 << QB, 100 << QB, 0, 0, QMAX, QMIN, 1, 1 << QB);
		push_item(200 << QB, 200 << QB, 30 << QB, 40 << QB, 0, 0, 1 << QB, 0);
		push_item(200 << QB, 200 << QB, 3 << QB, -(4 << QB), 0, 0, 1 << QB, 1 << QB);
		push_item(1 << QB, 300 << QB, -(5 << QB), 0, 0, 0, 1 << QB, 0);
		push_item(785 << QB, 300 << QB, 5 << QB, 0, 0, 0, 1 << QB, 0);
		push_item(400 << QB, 1 << QB, 0, -(5 << QB), 0, 0, 1 << QB, 0);
		push_item(400 << QB, 585 << QB, 0, 5 << QB, 0, 0, 1 << QB, 0);
		push_item(790 << QB, 590 << QB, 0, 0, 0, 0, 1 << QB, 0);
		push_item(-(1000 << QB), -(1000 << QB), 1, -1, 7, -7, 3, 5);
		push_item(QMAX - 3, QMIN + 3, 8 << QB, -(8 << QB), 0, 0, 32'hFFFF_FFFF, 20'hFFFFF);
		push_item(50 << QB, 60 << QB, -1, 1, -(1 << QB), 1 << QB, 2 << QB, 20'h00444);
		push_item(50 << QB, 60 << QB, 0, 0, QMIN, QMAX, 32'h8000_0000, 20'h80000);
		wait_idle();
		push_random(300);
		wait_idle();

		set_all(1, 0, 16777216, 0, 0, 65536);
		write_reg(CFG_SPARE_A, 32'h7FFF_FFFF);
		write_reg(CFG_SPARE_B, 123);
		push_item(0, 0, 1 << QB, 1 << QB, 0, 0, 1 << QB, 0);
		push_random(80);
		wait_idle();

		set_all(65535, 65535, 0, 2147483647, 131071, 131071);
		push_item(QMAX, QMIN, QMAX, QMIN, 0, 0, 0, 0);
		push_item(-1, 0, QMIN, QMAX, 0, 0, 0, 0);
		push_random(200);
		wait_idle();

		repeat (3) begin
			set_all($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 16777216), $urandom_range(0, 32'h7FFF_FFFF),
				$urandom_range(0, 131071), $urandom_range(0, 131071));
			push_random(100);
			wait_idle();
		end

		set_all(1024, 768, 4 << QB, 8 << QB, 32768, 58982);
		push_random(150);
		wait_idle();
		gaps_on = 1'b0;
		push_random(150);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d particles under %0d register settings plus reset defaults,",
			accepted, settings_run);
		$display("including zero density, wall bounces, speed limiting and saturation.");
		if (errors == 0 && expected_motion.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_motion.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pvib_pkg.sv
hw/rtl/pvib_div.sv
hw/rtl/pvib_sqrt.sv
hw/rtl/pvib_wall.sv
hw/rtl/particle_velocity_integrate_bounce.sv
test/tb_top.sv
